// File: src/signed_bcd_codec_adder_core_assert.svh
// Assertion macros for the signed BCD codec and adder core.
`ifndef SIGNED_BCD_CODEC_ADDER_CORE_ASSERT_SVH
`define SIGNED_BCD_CODEC_ADDER_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SBCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SBCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sbcd_pkg.sv
// Shared widths, field offsets and codes of the signed BCD codec and adder.
`default_nettype none

package sbcd_pkg;

    localparam int unsigned BIN_W     = 32;
    localparam int unsigned BCD_W     = 44;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned NIB_W     = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 4;

    // Slave tdata: bin_value, bcd_a, bcd_b
    localparam int unsigned S_BIN_LSB = 0;
    localparam int unsigned S_A_LSB   = S_BIN_LSB + BIN_W;
    localparam int unsigned S_B_LSB   = S_A_LSB + BCD_W;
    localparam int unsigned S_TDATA_W = ((S_B_LSB + BCD_W + 7) / 8) * 8;

    // Master tdata: bin_result, bcd_result, overflow, zero fill
    localparam int unsigned M_FIELD_W = BIN_W + BCD_W + 1;
    localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W   = M_TDATA_W - M_FIELD_W;

    localparam logic [OP_W-1:0] OP_ENCODE = 2'd0;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NEG_SIGN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SIGN = 1'd1;

    localparam logic [NIB_W-1:0] NEG_SIGN_RST = 4'd1;
    localparam logic [NIB_W-1:0] POS_SIGN_RST = 4'd0;

endpackage

`default_nettype wire

// File: src/signed_bcd_codec_adder_core.sv
// Signed BCD encode / decode / add core, a pipeline of digit and bit iteration stages.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+------------------------------------------
//  s        | in  | i_s_tvalid / o_s_tready  | tdata: bin_value, bcd_a, bcd_b; tuser: op
//  m        | out | o_m_tvalid / i_m_tready  | tdata: bin_result, bcd_result, overflow
//  cfg      | in  | i_cfg_wr_en              | i_cfg_addr, i_cfg_data (sign codes)
//
//  One request enters per cycle while o_s_tready is high; a stalled output holds the flow.
//  The pipeline has 16 iteration stages: two double-dabble bits, at most one decode
//  digit or one add digit per stage, plus an input stage and the output register.
//  Each stage takes new data when empty or when the stage after it moves, so a
//  stalled output fills the bubbles ahead of it before o_s_tready drops.
//  Reset clears valid bits and sets the sign codes to 1 (negative) and 0 (positive).
`default_nettype none

`include "signed_bcd_codec_adder_core_assert.svh"

module signed_bcd_codec_adder_core
    import sbcd_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // request stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // [31:0] bin_value, [75:32] bcd_a,
                                                  // [119:76] bcd_b
    input  wire logic [OP_W-1:0]      i_s_tuser,  // [1:0] op
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata   // [31:0] bin_result, [75:32] bcd_result,
                                                  // [76] overflow, [79:77] zero
);

    localparam int unsigned DW      = NIB_W * NUM_DIGITS;
    localparam int unsigned WW      = DW + NIB_W;
    localparam int unsigned NSTEP   = 16;
    localparam int unsigned DD_PER  = BIN_W / NSTEP;
    localparam int unsigned DIG_PER = (NUM_DIGITS + NSTEP - 1) / NSTEP;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             neg;
        logic [NIB_W-1:0] sign;
        logic [BIN_W-1:0] bin;    // encode: bits left to shift; decode: accumulator
        logic [DW-1:0]    dig;    // encode: BCD digits; decode/add: digits to consume
        logic [DW-1:0]    dig_b;
        logic             cy;
    } t_stage;

    typedef struct packed {
        logic             ovf;
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } t_res;

    // Ten's complement of a digit string; also the decode borrow-then-nines step.
    function automatic logic [DW-1:0] tens_comp(input logic [DW-1:0] d);
        logic             z;
        logic [NIB_W-1:0] x;
        logic [DW-1:0]    r;
        z = 1'b1;
        r = '0;
        for (int unsigned k = 0; k < NUM_DIGITS; k++) begin
            x = d[NIB_W*k +: NIB_W];
            if (z) begin
                r[NIB_W*k +: NIB_W] = (x == 4'd0) ? 4'd0 : 4'(4'd10 - x);
            end else begin
                r[NIB_W*k +: NIB_W] = 4'(4'd9 - x);
            end
            z = z && (x == 4'd0);
        end
        return r;
    endfunction

    function automatic t_stage step(input t_stage s, input int unsigned j);
        t_stage           r;
        logic [4:0]       sum;
        logic [NIB_W-1:0] x;
        r = s;
        unique case (s.op)
            OP_ENCODE: begin
                for (int unsigned t = 0; t < DD_PER; t++) begin
                    for (int unsigned k = 0; k < NUM_DIGITS; k++) begin
                        if (r.dig[NIB_W*k +: NIB_W] >= 4'd5) begin
                            r.dig[NIB_W*k +: NIB_W] = r.dig[NIB_W*k +: NIB_W] + 4'd3;
                        end
                    end
                    {r.dig, r.bin} = {r.dig[DW-2:0], r.bin, 1'b0};
                end
            end
            OP_DECODE: begin
                for (int unsigned t = 0; t < DIG_PER; t++) begin
                    if (j * DIG_PER + t < NUM_DIGITS) begin
                        // consume the top digit, then move the next one up
                        x     = r.dig[DW-1 -: NIB_W];
                        r.bin = (r.bin << 3) + (r.bin << 1) + BIN_W'(x);
                        r.dig = {r.dig[DW-NIB_W-1:0], {NIB_W{1'b0}}};
                    end
                end
            end
            OP_ADD: begin
                for (int unsigned t = 0; t < DIG_PER; t++) begin
                    if (j * DIG_PER + t < NUM_DIGITS) begin
                        sum = 5'(r.dig[NIB_W-1:0]) + 5'(r.dig_b[NIB_W-1:0]) + 5'(r.cy);
                        if (sum >= 5'd10) begin
                            x    = 4'(sum - 5'd10);
                            r.cy = 1'b1;
                        end else begin
                            x    = sum[NIB_W-1:0];
                            r.cy = 1'b0;
                        end
                        // rotate the sum digit in at the top
                        r.dig   = {x, r.dig[DW-1:NIB_W]};
                        r.dig_b = {{NIB_W{1'b0}}, r.dig_b[DW-1:NIB_W]};
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    logic [NIB_W-1:0] r_neg_code;
    logic [NIB_W-1:0] r_pos_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_code <= NEG_SIGN_RST;
            r_pos_code <= POS_SIGN_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_NEG_SIGN: r_neg_code <= i_cfg_data;
                REG_POS_SIGN: r_pos_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: unpack, take magnitude, detect decode sign, pre-complement digits
    logic [BIN_W-1:0] in_raw;
    logic [WW-1:0]    in_a;
    logic [WW-1:0]    in_b;
    logic             dec_neg;
    t_stage           n_stg0;

    assign in_raw  = i_s_tdata[S_BIN_LSB +: BIN_W];
    assign in_a    = WW'(i_s_tdata[S_A_LSB +: BCD_W]);
    assign in_b    = WW'(i_s_tdata[S_B_LSB +: BCD_W]);
    assign dec_neg = (in_a[WW-1:DW] == r_neg_code);

    always_comb begin
        n_stg0.op    = i_s_tuser;
        n_stg0.neg   = 1'b0;
        n_stg0.sign  = in_a[WW-1:DW];
        n_stg0.bin   = '0;
        n_stg0.dig   = in_a[DW-1:0];
        n_stg0.dig_b = in_b[DW-1:0];
        n_stg0.cy    = 1'b0;
        unique case (i_s_tuser)
            OP_ENCODE: begin
                n_stg0.neg  = in_raw[BIN_W-1];
                n_stg0.sign = in_raw[BIN_W-1] ? r_neg_code : r_pos_code;
                n_stg0.bin  = in_raw[BIN_W-1] ? BIN_W'(-in_raw) : in_raw;
                n_stg0.dig  = '0;
            end
            OP_DECODE: begin
                n_stg0.neg = dec_neg;
                if (dec_neg) begin
                    n_stg0.dig = tens_comp(in_a[DW-1:0]);
                end
            end
            default: ;
        endcase
    end

    t_stage           r_stg [NSTEP+1];
    logic [NSTEP:0]   r_vld;
    logic [NSTEP+1:0] rdy;
    t_res             r_out;
    t_res             n_out;
    logic             r_ovld;

    // A stage moves when empty or when the one after it moves.
    always_comb begin
        rdy[NSTEP+1] = !r_ovld || i_m_tready;
        for (int k = NSTEP; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_s_tready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_stg[0] <= n_stg0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (rdy[0]) begin
            r_vld[0] <= i_s_tvalid;
        end
    end

    for (genvar g = 0; g < NSTEP; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (rdy[g+1]) begin
                r_stg[g+1] <= step(r_stg[g], g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (rdy[g+1]) begin
                r_vld[g+1] <= r_vld[g];
            end
        end
    end

    // Output stage: finish the encode complement and decode negation, pass the add sum and carry, zero unused fields
    t_stage        last;
    logic [DW-1:0] enc_dig;

    assign last    = r_stg[NSTEP];
    assign enc_dig = last.neg ? tens_comp(last.dig) : last.dig;

    always_comb begin
        n_out = '0;
        unique case (last.op)
            OP_ENCODE: n_out.bcd = BCD_W'({last.sign, enc_dig});
            OP_DECODE: n_out.bin = last.neg ? BIN_W'(-last.bin) : last.bin;
            OP_ADD: begin
                n_out.bcd = BCD_W'({last.sign, last.dig});
                n_out.ovf = last.cy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (rdy[NSTEP+1]) begin
            r_ovld <= r_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NSTEP+1]) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_out};

    `SBCD_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_vld[NSTEP] && rdy[NSTEP+1], o_m_tvalid, "result lost on its way into the output register")
    `SBCD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_vld[0] && !rdy[1], r_vld[0] && $stable(r_stg[0]), "stalled input stage changed")
    `SBCD_ASSERT_SAME(a_enc_done, i_clk, i_rst_n, r_vld[NSTEP] && (last.op == OP_ENCODE), last.bin == '0, "binary bits left after the last shift stage")

endmodule

`default_nettype wire
